>>> src/atsd_pkg.sv
// ----------------------------------------------------------------------------
// Additive tone synthesiser package
// Shared constants, codes, types and constant functions of the synthesiser.
// ----------------------------------------------------------------------------
package atsd_pkg;

  // Default structural parameters.
  localparam int NUM_VOICES_DEF      = 13;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SAMPLE_RATE_HZ_DEF  = 48000;

  // Field and register widths.
  localparam int KEY_W       = 8;
  localparam int SAMPLE_W    = 24;
  localparam int AMP_W       = 24;
  localparam int PHASE_W     = 24;
  localparam int GAIN_W      = 16;
  localparam int PERIOD_W    = 20;
  localparam int DECAY_W     = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int SINE_MAG_W  = 23;
  localparam int MUL_W       = 25;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int ACC_W       = 48;

  // Register reset values.
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd4096;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd96000;
  localparam logic [DECAY_W-1:0]  DECAY_RESET  = 24'd16775538;

  // Full-scale amplitude, 1.0 in Q1.23.
  localparam logic [AMP_W-1:0] AMP_ONE = 24'd8388608;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_VOICE_GAIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECAY      = 2'd2;

  // Input action codes.
  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Taylor coefficients of the sine polynomial, Q30.
  localparam longint unsigned K1  = 64'd1686629713;
  localparam longint unsigned K3  = 64'd693598668;
  localparam longint unsigned K5  = 64'd85569306;
  localparam longint unsigned K7  = 64'd5026995;
  localparam longint unsigned K9  = 64'd172272;
  localparam longint unsigned K11 = 64'd3864;
  localparam longint unsigned SINE_MAX = 64'd8388607;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROM,
    ST_SINE,
    ST_GAIN,
    ST_DECAY,
    ST_UPD,
    ST_MIX
  } state_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] voice;
  } key_map_t;

  // Scan code to voice, ascending semitones from C.
  function automatic key_map_t key_to_voice(input logic [KEY_W-1:0] key);
    key_map_t m;
    m.hit = 1'b1;
    unique case (key)
      8'd16:   m.voice = 5'd0;
      8'd3:    m.voice = 5'd1;
      8'd17:   m.voice = 5'd2;
      8'd4:    m.voice = 5'd3;
      8'd18:   m.voice = 5'd4;
      8'd19:   m.voice = 5'd5;
      8'd6:    m.voice = 5'd6;
      8'd20:   m.voice = 5'd7;
      8'd7:    m.voice = 5'd8;
      8'd21:   m.voice = 5'd9;
      8'd8:    m.voice = 5'd10;
      8'd22:   m.voice = 5'd11;
      8'd23:   m.voice = 5'd12;
      default: begin
        m.hit   = 1'b0;
        m.voice = 5'd0;
      end
    endcase
    return m;
  endfunction

  // Equal-tempered note frequencies in millihertz, from middle C upwards.
  function automatic logic [31:0] note_mhz(input int unsigned idx);
    logic [31:0] f;
    unique case (idx[4:0])
      5'd0:  f = 32'd261626;
      5'd1:  f = 32'd277183;
      5'd2:  f = 32'd293665;
      5'd3:  f = 32'd311127;
      5'd4:  f = 32'd329628;
      5'd5:  f = 32'd349228;
      5'd6:  f = 32'd369994;
      5'd7:  f = 32'd391995;
      5'd8:  f = 32'd415305;
      5'd9:  f = 32'd440000;
      5'd10: f = 32'd466164;
      5'd11: f = 32'd493883;
      5'd12: f = 32'd523251;
      5'd13: f = 32'd554365;
      5'd14: f = 32'd587330;
      5'd15: f = 32'd622254;
      5'd16: f = 32'd659255;
      5'd17: f = 32'd698456;
      5'd18: f = 32'd739989;
      5'd19: f = 32'd783991;
      5'd20: f = 32'd830609;
      5'd21: f = 32'd880000;
      5'd22: f = 32'd932328;
      5'd23: f = 32'd987767;
      5'd24: f = 32'd1046502;
      5'd25: f = 32'd1108731;
      5'd26: f = 32'd1174659;
      5'd27: f = 32'd1244508;
      5'd28: f = 32'd1318510;
      5'd29: f = 32'd1396913;
      5'd30: f = 32'd1479978;
      5'd31: f = 32'd1567982;
    endcase
    return f;
  endfunction

  // Quarter-wave table entry j of 2^bits: sin(pi/2 * j / 2^bits) in Q1.23.
  // Only ever evaluated at elaboration to build the table contents.
  function automatic logic [SINE_MAG_W-1:0] sine_entry(input longint unsigned j,
                                                      input int unsigned bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned s;
    longint unsigned v;
    x  = (j << 30) >> bits;
    x2 = (x * x) >> 30;
    p  = K11;
    p  = K9 - ((x2 * p) >> 30);
    p  = K7 - ((x2 * p) >> 30);
    p  = K5 - ((x2 * p) >> 30);
    p  = K3 - ((x2 * p) >> 30);
    p  = K1 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    v  = (s + 64'd64) >> 7;
    if (v > SINE_MAX) begin
      v = SINE_MAX;
    end
    return v[SINE_MAG_W-1:0];
  endfunction

endpackage

>>> src/atsd_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 25 x 25 multiplier with a registered product, time-shared by the
// sequencer for the sine, gain and decay products.
// ----------------------------------------------------------------------------
module atsd_mul (
  input  logic                                clk,
  input  logic signed [atsd_pkg::MUL_W-1:0]   a,
  input  logic signed [atsd_pkg::MUL_W-1:0]   b,
  output logic signed [atsd_pkg::PROD_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> src/atsd_sine_rom.sv
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Maps a phase to a signed Q1.23 sine through a quarter-wave ROM with
// quadrant mirroring and negation. The table read and the sign are registered.
// ----------------------------------------------------------------------------
module atsd_sine_rom #(
  parameter int SINE_TABLE_BITS = atsd_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic        [atsd_pkg::PHASE_W-1:0]   phase,
  output logic signed [atsd_pkg::SAMPLE_W-1:0]  sine
);

  localparam int TB    = SINE_TABLE_BITS;
  localparam int DEPTH = (1 << TB) + 1;

  logic [atsd_pkg::SINE_MAG_W-1:0] rom [DEPTH];
  logic [atsd_pkg::SINE_MAG_W-1:0] mag;
  logic [TB-1:0]                   idx;
  logic [TB:0]                     j;
  logic                            neg;

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    assign rom[k] = atsd_pkg::sine_entry(longint'(k), TB);
  end

  // Odd quadrants run the table backwards.
  assign idx = phase[atsd_pkg::PHASE_W-3 -: TB];
  assign j   = phase[atsd_pkg::PHASE_W-2] ? ((TB+1)'(1 << TB) - {1'b0, idx})
                                          : {1'b0, idx};

  always_ff @(posedge clk) begin
    mag <= rom[j];
    neg <= phase[atsd_pkg::PHASE_W-1];
  end

  assign sine = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

>>> src/additive_tone_synth_with_decay.sv
// ----------------------------------------------------------------------------
// Additive tone synthesiser with decay
// Multi-voice sine synthesiser for one octave with key-driven voices,
// per-sample exponential decay and periodic phase restart.
// ----------------------------------------------------------------------------
// A key event item (action 0) sets the mapped voice to full amplitude on a
// press and silences it on a release; unmapped codes are ignored. A key event
// is taken while the block is idle, leaves it idle and produces no result.
// A sample tick item (action 1) produces one mixed 24-bit sample: the block
// walks the voices one at a time through a single shared 25 x 25 multiplier,
// five steps per voice (sine table read, amplitude x sine, gain, decay,
// write-back), followed by a mix step to truncate and saturate the mix. A tick
// therefore holds the input ready low until its mix step is done. The
// finished sample sits in an output register, so the next item is taken
// while it waits to be read; the mix step only stalls if the previous
// sample has still not been taken. Configuration writes are accepted in
// every cycle and should only be made while the block is idle. Writes to
// an index beyond the three registers are ignored.
// ----------------------------------------------------------------------------
module additive_tone_synth_with_decay #(
  parameter int NUM_VOICES      = atsd_pkg::NUM_VOICES_DEF,
  parameter int SINE_TABLE_BITS = atsd_pkg::SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_RATE_HZ  = atsd_pkg::SAMPLE_RATE_HZ_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [atsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [atsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  action,
  input  logic        [atsd_pkg::KEY_W-1:0]     key_code,
  input  logic                                  pressed,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [atsd_pkg::SAMPLE_W-1:0]  sample
);

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam longint unsigned DEN = longint'(SAMPLE_RATE_HZ) * 64'd1000;
  localparam int AW = atsd_pkg::AMP_W;
  localparam int PW = atsd_pkg::PHASE_W;
  localparam int MW = atsd_pkg::MUL_W;
  localparam int RW = atsd_pkg::PROD_W;
  localparam int CW = atsd_pkg::ACC_W;

  // Configuration registers.
  logic [atsd_pkg::GAIN_W-1:0]   voice_gain;
  logic [atsd_pkg::PERIOD_W-1:0] period_samples;
  logic [atsd_pkg::DECAY_W-1:0]  decay_factor;

  // Voice state.
  logic [AW-1:0] amp   [NUM_VOICES];
  logic [PW-1:0] phase [NUM_VOICES];
  logic [PW-1:0] inc_tab [NUM_VOICES];
  logic [atsd_pkg::PERIOD_W-1:0] sample_count;

  atsd_pkg::state_t state, state_next;
  logic [VW-1:0]    vidx;
  logic signed [CW-1:0] acc;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [RW-1:0] prod;
  logic signed [RW-1:0] prod_biased;
  logic signed [MW-1:0] v;
  logic signed [atsd_pkg::SAMPLE_W-1:0] sine;
  logic signed [CW-1:0] acc_biased;
  logic signed [MW-1:0] mix_q;
  logic signed [atsd_pkg::SAMPLE_W-1:0] mix_sat;

  atsd_pkg::key_map_t key_map;
  logic key_hit;
  logic tick_accept, key_accept, last_voice, mix_load;
  logic [atsd_pkg::PERIOD_W-1:0] count_inc;
  logic period_end;

  // Phase increments per voice: round(f * 2^24 / fs), worked out at
  // elaboration from the note table.
  for (genvar gi = 0; gi < NUM_VOICES; gi++) begin : g_inc
    localparam longint unsigned NUM = longint'(atsd_pkg::note_mhz(gi)) << 24;
    localparam logic [PW-1:0] INC = PW'((NUM + DEN / 2) / DEN);
    assign inc_tab[gi] = INC;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_gain     <= atsd_pkg::GAIN_RESET;
      period_samples <= atsd_pkg::PERIOD_RESET;
      decay_factor   <= atsd_pkg::DECAY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        atsd_pkg::CFG_VOICE_GAIN: voice_gain     <= cfg_data[atsd_pkg::GAIN_W-1:0];
        atsd_pkg::CFG_PERIOD:     period_samples <= cfg_data[atsd_pkg::PERIOD_W-1:0];
        atsd_pkg::CFG_DECAY:      decay_factor   <= cfg_data[atsd_pkg::DECAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      atsd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && action == atsd_pkg::ACT_TICK) begin
          state_next = atsd_pkg::ST_ROM;
        end
      end
      atsd_pkg::ST_ROM:   state_next = atsd_pkg::ST_SINE;
      atsd_pkg::ST_SINE:  state_next = atsd_pkg::ST_GAIN;
      atsd_pkg::ST_GAIN:  state_next = atsd_pkg::ST_DECAY;
      atsd_pkg::ST_DECAY: state_next = atsd_pkg::ST_UPD;
      atsd_pkg::ST_UPD: begin
        state_next = last_voice ? atsd_pkg::ST_MIX : atsd_pkg::ST_ROM;
      end
      atsd_pkg::ST_MIX: begin
        if (!out_valid || out_ready) begin
          state_next = atsd_pkg::ST_IDLE;
        end
      end
      default: state_next = atsd_pkg::ST_IDLE;
    endcase
  end

  assign tick_accept = in_valid && in_ready && (action == atsd_pkg::ACT_TICK);
  assign key_accept  = in_valid && in_ready && (action == atsd_pkg::ACT_KEY);
  assign last_voice  = (vidx == VW'(NUM_VOICES - 1));
  assign mix_load    = (state == atsd_pkg::ST_MIX) && (!out_valid || out_ready);

  assign key_map = atsd_pkg::key_to_voice(key_code);
  assign key_hit = key_map.hit && ({1'b0, key_map.voice} < 6'(NUM_VOICES));

  // Shared multiplier and the sine table feeding it.
  atsd_sine_rom #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine (
    .clk   (clk),
    .phase (phase[vidx]),
    .sine  (sine)
  );

  atsd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Operand selection: amplitude x sine, then the voice term x gain, then
  // amplitude x decay.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      atsd_pkg::ST_SINE: begin
        mul_a = $signed({1'b0, amp[vidx]});
        mul_b = MW'(sine);
      end
      atsd_pkg::ST_GAIN: begin
        mul_a = v;
        mul_b = $signed({{(MW - atsd_pkg::GAIN_W){1'b0}}, voice_gain});
      end
      atsd_pkg::ST_DECAY: begin
        mul_a = $signed({1'b0, amp[vidx]});
        mul_b = $signed({1'b0, decay_factor});
      end
      default: begin
      end
    endcase
  end

  // Voice term: amplitude x sine / 2^23, truncated towards zero.
  assign prod_biased = prod + (prod[RW-1] ? RW'(64'd8388607) : RW'(0));
  assign v           = prod_biased[MW+22:23];

  // Mix: sum / 2^23 truncated towards zero, then saturated to 24 bits.
  assign acc_biased = acc + (acc[CW-1] ? CW'(64'd8388607) : CW'(0));
  assign mix_q      = acc_biased[MW+22:23];

  always_comb begin
    if (mix_q > MW'(32'sd8388607)) begin
      mix_sat = 24'sh7FFFFF;
    end else if (mix_q < -MW'(32'sd8388608)) begin
      mix_sat = 24'sh800000;
    end else begin
      mix_sat = mix_q[atsd_pkg::SAMPLE_W-1:0];
    end
  end

  assign count_inc  = sample_count + atsd_pkg::PERIOD_W'(1);
  assign period_end = (count_inc >= period_samples);

  // Voice index and accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      vidx <= '0;
    end else if (tick_accept) begin
      vidx <= '0;
    end else if (state == atsd_pkg::ST_UPD) begin
      vidx <= last_voice ? '0 : vidx + VW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      acc <= '0;
    end else if (state == atsd_pkg::ST_DECAY) begin
      acc <= acc + prod[CW-1:0];
    end
  end

  // Amplitudes: set by key events, decayed once per tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        amp[i] <= '0;
      end
    end else if (key_accept && key_hit) begin
      amp[key_map.voice[VW-1:0]] <= pressed ? atsd_pkg::AMP_ONE : '0;
    end else if (state == atsd_pkg::ST_UPD) begin
      amp[vidx] <= prod[2*AW-1:AW];
    end
  end

  // Phases: advanced once per tick, all restarted at the end of a period.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        phase[i] <= '0;
      end
    end else if (mix_load && period_end) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        phase[i] <= '0;
      end
    end else if (state == atsd_pkg::ST_UPD) begin
      phase[vidx] <= phase[vidx] + inc_tab[vidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (mix_load) begin
      sample_count <= period_end ? '0 : count_inc;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mix_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_load) begin
      sample <= mix_sat;
    end
  end

`ifndef SYNTH
  // A tick keeps the block busy; a key event leaves it ready.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    tick_accept |=> !in_ready)
    else $error("input ready after a sample tick was accepted");

  a_key_ready: assert property (@(posedge clk) disable iff (rst)
    key_accept |=> in_ready)
    else $error("key event left the block busy");

  // A new sample appears only out of the mix step.
  a_out_from_mix: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == atsd_pkg::ST_MIX)
    else $error("sample presented outside the mix step");

  a_vidx_range: assert property (@(posedge clk) disable iff (rst)
    vidx <= VW'(NUM_VOICES - 1))
    else $error("voice index beyond the last voice");
`endif

endmodule

>>> test/additive_tone_synth_with_decay_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Additive tone synthesiser checker
// Watches the register, input and output channels of the synthesiser, keeps
// its own model of the voices, and compares every sample that is read out.
// ----------------------------------------------------------------------------
module additive_tone_synth_with_decay_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic        [atsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [atsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic                                   action,
  input  logic        [atsd_pkg::KEY_W-1:0]      key_code,
  input  logic                                   pressed,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic signed [atsd_pkg::SAMPLE_W-1:0]   sample,
  output int                                     failures,
  output int                                     pending
);
  import atsd_pkg::*;

  localparam int VOICES     = NUM_VOICES_DEF;
  localparam int TABLE_BITS = SINE_TABLE_BITS_DEF;
  localparam int RATE_HZ    = SAMPLE_RATE_HZ_DEF;
  localparam int REPORT_MAX = 10;

  localparam logic [15:0] GAIN_AT_RESET   = 16'd4096;
  localparam logic [19:0] PERIOD_AT_RESET = 20'd96000;
  localparam logic [23:0] DECAY_AT_RESET  = 24'd16775538;
  localparam logic [23:0] FULL_LEVEL      = 24'h800000;

  // Odd Taylor terms of sin(pi/2 * x), Q30.
  localparam longint unsigned T1  = 64'd1686629713;
  localparam longint unsigned T3  = 64'd693598668;
  localparam longint unsigned T5  = 64'd85569306;
  localparam longint unsigned T7  = 64'd5026995;
  localparam longint unsigned T9  = 64'd172272;
  localparam longint unsigned T11 = 64'd3864;

  logic        [15:0] gain;
  logic        [19:0] period;
  logic        [23:0] decay;
  logic        [23:0] level [VOICES];
  logic        [23:0] angle [VOICES];
  logic        [19:0] ticks_in_period;
  logic signed [23:0] expected_samples [$];
  logic signed [23:0] want;
  int                 fail_cnt = 0;
  int                 hit_voice;

  function automatic int voice_of_key(input logic [7:0] key);
    case (key)
      8'd16:   return 0;
      8'd3:    return 1;
      8'd17:   return 2;
      8'd4:    return 3;
      8'd18:   return 4;
      8'd19:   return 5;
      8'd6:    return 6;
      8'd20:   return 7;
      8'd7:    return 8;
      8'd21:   return 9;
      8'd8:    return 10;
      8'd22:   return 11;
      8'd23:   return 12;
      default: return -1;
    endcase
  endfunction

  function automatic longint unsigned note_millihz(input int v);
    case (v)
      0:       return 64'd261626;
      1:       return 64'd277183;
      2:       return 64'd293665;
      3:       return 64'd311127;
      4:       return 64'd329628;
      5:       return 64'd349228;
      6:       return 64'd369994;
      7:       return 64'd391995;
      8:       return 64'd415305;
      9:       return 64'd440000;
      10:      return 64'd466164;
      11:      return 64'd493883;
      default: return 64'd523251;
    endcase
  endfunction

  // Phase advance per sample, full turn = 2^24, rounded to nearest.
  function automatic logic [23:0] note_step(input int v);
    longint unsigned den;
    longint unsigned step;
    den  = longint'(RATE_HZ) * 64'd1000;
    step = ((note_millihz(v) << 24) + den / 64'd2) / den;
    return step[23:0];
  endfunction

  function automatic longint sine_of(input logic [23:0] ph);
    logic [1:0]      quad;
    longint unsigned q;
    longint unsigned idx;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned v;
    q    = 64'd1 << TABLE_BITS;
    quad = ph[23:22];
    idx  = longint'(ph >> (22 - TABLE_BITS)) & (q - 64'd1);
    if (quad[0]) begin
      idx = q - idx;
    end
    x  = (idx << 30) >> TABLE_BITS;
    x2 = (x * x) >> 30;
    p  = T11;
    p  = T9 - ((x2 * p) >> 30);
    p  = T7 - ((x2 * p) >> 30);
    p  = T5 - ((x2 * p) >> 30);
    p  = T3 - ((x2 * p) >> 30);
    p  = T1 - ((x2 * p) >> 30);
    v  = (((x * p) >> 30) + 64'd64) >> 7;
    if (v > 64'd8388607) begin
      v = 64'd8388607;
    end
    return quad[1] ? -longint'(v) : longint'(v);
  endfunction

  // Mixes one sample and moves every voice on by one tick.
  function automatic logic signed [23:0] render_sample();
    longint          acc;
    longint          part;
    longint unsigned decayed;
    acc = 0;
    for (int i = 0; i < VOICES; i++) begin
      part    = (longint'(level[i]) * sine_of(angle[i])) / 64'sd8388608;
      acc     = acc + part * longint'(gain);
      decayed = longint'(level[i]) * longint'(decay);
      level[i] = decayed[47:24];
      angle[i] = angle[i] + note_step(i);
    end
    acc = acc / 64'sd8388608;
    if (acc > 64'sd8388607) begin
      acc = 64'sd8388607;
    end else if (acc < -64'sd8388608) begin
      acc = -64'sd8388608;
    end
    ticks_in_period = ticks_in_period + 20'd1;
    if (ticks_in_period >= period) begin
      ticks_in_period = '0;
      for (int i = 0; i < VOICES; i++) begin
        angle[i] = '0;
      end
    end
    return acc[23:0];
  endfunction

  // A sample read out in a cycle always belongs to an earlier tick, so the
  // output is checked before the item of the same cycle is modelled.
  always @(posedge clk) begin
    if (rst) begin
      gain            = GAIN_AT_RESET;
      period          = PERIOD_AT_RESET;
      decay           = DECAY_AT_RESET;
      ticks_in_period = '0;
      for (int i = 0; i < VOICES; i++) begin
        level[i] = '0;
        angle[i] = '0;
      end
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VOICE_GAIN: gain   = cfg_data[15:0];
          CFG_PERIOD:     period = cfg_data[19:0];
          CFG_DECAY:      decay  = cfg_data[23:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX) begin
            $display("%0t: sample %0d read with none outstanding", $realtime, sample);
          end
        end else begin
          want = expected_samples.pop_front();
          if (sample !== want) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX) begin
              $display("%0t: sample mismatch, expected %0d, got %0d", $realtime, want,
                       sample);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        if (action == ACT_TICK) begin
          expected_samples.push_back(render_sample());
        end else begin
          hit_voice = voice_of_key(key_code);
          if (hit_voice >= 0 && hit_voice < VOICES) begin
            level[hit_voice] = pressed ? FULL_LEVEL : '0;
          end
        end
      end
    end
    failures <= fail_cnt;
    pending  <= expected_samples.size();
  end

endmodule

>>> test/additive_tone_synth_with_decay_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Additive tone synthesiser testbench
// Drives key and tick items and register writes into the synthesiser, with
// bursty input and a stalling reader, and lets the checker judge the samples.
// ----------------------------------------------------------------------------
module additive_tone_synth_with_decay_tb;
  import atsd_pkg::*;

  // A tick keeps the block busy until its mix is done. After the last item
  // the bench waits out SETTLE_CYCLES so that any tick still under way can
  // reach its mix; the checker's count of outstanding samples then tells
  // when every sample has been read and the registers may be touched.
  localparam int SETTLE_CYCLES = 80;
  // Length of the single long read stall that backs the block up.
  localparam int LONG_HOLD     = 3000;

  // Index past the three registers; writes to it must be ignored.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {
    PH_DIRECTED,
    PH_LOUD,
    PH_SILENT,
    PH_SHORT_PERIOD,
    PH_SINGLE_TICK,
    PH_BACKPRESSURE
  } stim_phase_t;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic                    action    = ACT_KEY;
  logic [KEY_W-1:0]        key_code  = '0;
  logic                    pressed   = 1'b0;
  logic                    out_ready = 1'b0;
  logic                    cfg_ready;
  logic                    in_ready;
  logic                    out_valid;
  logic signed [SAMPLE_W-1:0] sample;
  int                      failures;
  int                      pending;
  stim_phase_t             stim_phase = PH_DIRECTED;
  bit                      long_hold_done = 1'b0;
  logic [KEY_W-1:0]        mapped_keys [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  additive_tone_synth_with_decay dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .key_code  (key_code),
    .pressed   (pressed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample)
  );

  additive_tone_synth_with_decay_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .key_code  (key_code),
    .pressed   (pressed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .failures  (failures),
    .pending   (pending)
  );

  // Offers one item and returns at the edge where it is taken. Valid is left
  // high so that a following item goes out back to back; the caller lowers
  // it when a gap is wanted.
  task automatic put_item(input logic act, input logic [KEY_W-1:0] key, input logic prs);
    in_valid <= 1'b1;
    action   <= act;
    key_code <= key;
    pressed  <= prs;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Register writes chain in the same way; the caller lowers cfg_valid.
  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
  endtask

  // Waits until the block has finished every item and all samples are read.
  task automatic drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  // Mostly ticks and presses or releases of mapped keys, so that chords build
  // up and decay; the rest is key events with arbitrary codes. Ticks carry
  // random key and press fields, which the block must not look at. Key
  // events on unmapped codes are not counted as useful work.
  task automatic pick_item(output logic act, output logic [KEY_W-1:0] key,
                           output logic prs, output bit counts);
    int       roll;
    key_map_t km;
    roll   = $urandom_range(0, 99);
    act    = ACT_TICK;
    key    = KEY_W'($urandom_range(0, 255));
    prs    = 1'($urandom_range(0, 1));
    counts = 1'b1;
    if (roll < 38) begin
      act = ACT_KEY;
      key = mapped_keys[$urandom_range(0, mapped_keys.size() - 1)];
      prs = ($urandom_range(0, 9) < 6);
    end else if (roll < 50) begin
      act    = ACT_KEY;
      km     = key_to_voice(key);
      counts = km.hit;
    end
  endtask

  // Sends items in bursts of random length. About a third of the bursts run
  // straight into the next one with no gap, the rest pause for a random gap,
  // so gaps land on every step of the block's per-voice walk.
  task automatic run_random(input int useful_items);
    int               sent;
    int               burst;
    int               gap;
    logic             act;
    logic [KEY_W-1:0] key;
    logic             prs;
    bit               counts;
    sent = 0;
    while (sent < useful_items) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        pick_item(act, key, prs, counts);
        put_item(act, key, prs);
        if (counts) begin
          sent++;
        end
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Reader: stretches of ready of random length, often followed by a short
  // stall. Once the last phase starts it stops reading for a long stretch,
  // so the output register stays full, the next tick cannot finish its mix
  // and the block stops taking items while the sender keeps offering them.
  initial begin
    @(posedge clk);
    forever begin
      if (!long_hold_done && stim_phase == PH_BACKPRESSURE) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        if ($urandom_range(0, 3) != 0) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 16)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    key_map_t km;
    // The list of mapped codes is taken from the block's own key map, so the
    // random part can aim at sounding voices most of the time.
    for (int k = 0; k < 256; k++) begin
      km = key_to_voice(KEY_W'(k));
      if (km.hit) begin
        mapped_keys.push_back(KEY_W'(k));
      end
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed items with the registers at their reset values. A tick while
    // all voices are silent, then codes that must be ignored (the old quit
    // code, code 5 and both extremes of the code range), then a single note,
    // a second one on the top C, and releases of a sounding note and of an
    // unmapped code.
    put_item(ACT_TICK, 8'hFF, 1'b1);
    put_item(ACT_KEY, 8'h2D, 1'b1);
    put_item(ACT_KEY, 8'd5, 1'b1);
    put_item(ACT_KEY, 8'd0, 1'b1);
    put_item(ACT_KEY, 8'hFF, 1'b1);
    put_item(ACT_KEY, 8'd16, 1'b1);
    put_item(ACT_TICK, 8'h00, 1'b0);
    put_item(ACT_KEY, 8'd23, 1'b1);
    put_item(ACT_TICK, 8'hAA, 1'b0);
    put_item(ACT_TICK, 8'h55, 1'b1);
    put_item(ACT_KEY, 8'd16, 1'b0);
    put_item(ACT_KEY, 8'd99, 1'b0);
    put_item(ACT_TICK, 8'h00, 1'b0);
    in_valid <= 1'b0;
    drain();

    // Loudest setting: full gain, the longest period and the slowest decay.
    // Every key is held down before the random part so that all thirteen
    // voices sound together at full gain.
    set_reg(CFG_VOICE_GAIN, {8'($urandom), 16'hFFFF});
    set_reg(CFG_PERIOD, {4'($urandom), 20'hFFFFF});
    set_reg(CFG_DECAY, 24'hFFFFFF);
    cfg_valid  <= 1'b0;
    stim_phase <= PH_LOUD;
    foreach (mapped_keys[i]) begin
      put_item(ACT_KEY, mapped_keys[i], 1'b1);
    end
    put_item(ACT_TICK, 8'h00, 1'b0);
    put_item(ACT_TICK, 8'hFF, 1'b1);
    run_random(300);
    drain();

    // No gain and a zero period, so the phases restart after every tick; the
    // spare index is written too and must change nothing.
    set_reg(CFG_VOICE_GAIN, {8'($urandom), 16'h0000});
    set_reg(CFG_PERIOD, {4'($urandom), 20'h00000});
    set_reg(CFG_DECAY, 24'($urandom));
    set_reg(CFG_SPARE, 24'($urandom));
    cfg_valid  <= 1'b0;
    stim_phase <= PH_SILENT;
    run_random(120);
    drain();

    // Short periods, so that the phase restart is crossed many times.
    set_reg(CFG_VOICE_GAIN, 24'($urandom));
    set_reg(CFG_PERIOD, 24'($urandom_range(2, 40)));
    set_reg(CFG_DECAY, 24'($urandom_range(16700000, 16777215)));
    cfg_valid  <= 1'b0;
    stim_phase <= PH_SHORT_PERIOD;
    run_random(350);
    drain();

    // A period of one tick and a zero decay, so every note lasts one sample.
    set_reg(CFG_SPARE, 24'($urandom));
    set_reg(CFG_VOICE_GAIN, 24'($urandom));
    set_reg(CFG_PERIOD, 24'd1);
    set_reg(CFG_DECAY, 24'd0);
    cfg_valid  <= 1'b0;
    stim_phase <= PH_SINGLE_TICK;
    run_random(100);
    drain();

    // Random long periods and slow decay, with the long read stall on top.
    set_reg(CFG_VOICE_GAIN, 24'($urandom));
    set_reg(CFG_PERIOD, 24'($urandom_range(1000, 1048575)));
    set_reg(CFG_DECAY, 24'($urandom_range(16000000, 16777215)));
    cfg_valid  <= 1'b0;
    stim_phase <= PH_BACKPRESSURE;
    run_random(330);
    drain();

    if (failures == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Safety net: fails the run if it has not finished by this time.
  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

endmodule
